>>> hdl/ccs_pkg.sv
package ccs_pkg;

    localparam int MAX_WINDOW_DEF  = 8192;
    localparam int THIS_SCAN_LIMIT = 48;
    localparam int MAX_PARAMS      = 12;

    localparam logic [7:0] OP_MOV_RM    = 8'h89;
    localparam logic [7:0] MODRM_ECX_BP = 8'h4D;
    localparam logic [7:0] DISP_NEG_MIN = 8'h80;
    localparam logic [7:0] OP_INT3      = 8'hCC;
    localparam logic [7:0] OP_POP_EBP   = 8'h5D;
    localparam logic [7:0] OP_LEAVE     = 8'hC9;
    localparam logic [7:0] OP_RET       = 8'hC3;
    localparam logic [7:0] OP_RET_IMM   = 8'hC2;
    localparam int         RET_MAX      = 256;
    localparam logic [7:0] MODRM_MASK   = 8'hC7;
    localparam logic [7:0] MODRM_BP_D8  = 8'h45;
    localparam logic [7:0] DISP_MIN     = 8'h08;
    localparam logic [7:0] DISP_MAX     = 8'h4C;

    localparam logic [1:0] CONV_CDECL    = 2'd0;
    localparam logic [1:0] CONV_STDCALL  = 2'd1;
    localparam logic [1:0] CONV_THISCALL = 2'd2;

    localparam logic signed [7:0] COUNT_UNKNOWN = -8'sd1;

    typedef struct packed {
        logic              valid;
        logic [1:0]        convention;
        logic signed [7:0] param_count;
    } result_t;

endpackage

>>> hdl/x86_calling_convention_scanner_top.sv
// channel   dir  payload                                        accept
// s_*       in   tdata[7:0] code_byte, tlast last_byte          s_tvalid && s_tready
// m_*       out  tdata[1:0] convention, [9:2] param_count       m_tvalid && m_tready
//
// one byte accepted per cycle while no last byte waits for space; a result passes
// the input register, then the scan logic into the result register
// rst_n clears the handshake flags and the scan state; payload registers are not reset
// a stalled result blocks only the last byte of the next body, other bytes keep flowing
module x86_calling_convention_scanner_top #(
    parameter int MAX_WINDOW = ccs_pkg::MAX_WINDOW_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] code_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [1:0] convention, [9:2] param_count, [15:10] zero
);

    logic             in_valid_reg;
    logic [7:0]       in_byte_reg;
    logic             in_last_reg;
    logic             space;
    logic             step;
    ccs_pkg::result_t res;

    // a last byte waits until the result register can take its result
    assign step     = in_valid_reg && (!in_last_reg || space);
    assign s_tready = !in_valid_reg || step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    ccs_scan #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .code_byte (in_byte_reg),
        .last_byte (in_last_reg),
        .res       (res)
    );

    ccs_outreg u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .res      (res),
        .space    (space),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

>>> hdl/ccs_scan.sv
module ccs_scan #(
    parameter int MAX_WINDOW = ccs_pkg::MAX_WINDOW_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic [7:0]       code_byte,
    input  logic             last_byte,
    output ccs_pkg::result_t res
);

    localparam int PW       = $clog2(MAX_WINDOW + 1);
    localparam int THIS_END = ccs_pkg::THIS_SCAN_LIMIT + 2;

    logic [PW-1:0]     pos_reg, pos_next;
    logic [7:0]        b1_reg, b1_next;
    logic [7:0]        b2_reg, b2_next;
    logic [7:0]        b3_reg, b3_next;
    logic              this_found_reg, this_found_next;
    logic              this_stop_reg, this_stop_next;
    logic              std_found_reg, std_found_next;
    logic signed [9:0] best_ret_reg, best_ret_next;
    logic [6:0]        max_disp_reg, max_disp_next;

    logic [31:0]       p;
    logic              in_win;
    logic [15:0]       ret_n;
    logic              ret_n_ok;
    logic signed [9:0] ret_n_s;
    logic [4:0]        disp_count;

    assign p        = 32'(pos_reg);
    assign in_win   = p < 32'(MAX_WINDOW);
    assign ret_n    = {code_byte, b1_reg};
    assign ret_n_ok = (ret_n <= 16'(ccs_pkg::RET_MAX)) && (ret_n[1:0] == 2'b00);
    assign ret_n_s  = $signed({1'b0, ret_n[8:0]});

    always_comb
    begin
        pos_next        = pos_reg;
        b1_next         = b1_reg;
        b2_next         = b2_reg;
        b3_next         = b3_reg;
        this_found_next = this_found_reg;
        this_stop_next  = this_stop_reg;
        std_found_next  = std_found_reg;
        best_ret_next   = best_ret_reg;
        max_disp_next   = max_disp_reg;

        if (in_win)
        begin
            // mov [ebp-N],ecx starting two bytes back
            if (p >= 32'd5 && !this_found_reg && !this_stop_reg && p < 32'(THIS_END))
            begin
                if (b2_reg == ccs_pkg::OP_MOV_RM && b1_reg == ccs_pkg::MODRM_ECX_BP &&
                    code_byte >= ccs_pkg::DISP_NEG_MIN)
                begin
                    this_found_next = 1'b1;
                end
                else if (b2_reg == ccs_pkg::OP_INT3)
                begin
                    this_stop_next = 1'b1;
                end
            end

            // epilogue then ret imm16
            if (p >= 32'd3 && (b3_reg == ccs_pkg::OP_POP_EBP || b3_reg == ccs_pkg::OP_LEAVE) &&
                b2_reg == ccs_pkg::OP_RET_IMM)
            begin
                if (ret_n_ok && ret_n_s > best_ret_reg)
                begin
                    best_ret_next  = ret_n_s;
                    std_found_next = 1'b1;
                end
            end

            // epilogue then plain ret (never on the same byte as ret imm16)
            if (p >= 32'd2 && (b2_reg == ccs_pkg::OP_POP_EBP || b2_reg == ccs_pkg::OP_LEAVE) &&
                b1_reg == ccs_pkg::OP_RET)
            begin
                if (best_ret_reg < 10'sd0)
                begin
                    best_ret_next = 10'sd0;
                end
            end

            if (p >= 32'd2 && (b1_reg & ccs_pkg::MODRM_MASK) == ccs_pkg::MODRM_BP_D8)
            begin
                if (code_byte >= ccs_pkg::DISP_MIN && code_byte <= ccs_pkg::DISP_MAX &&
                    code_byte[1:0] == 2'b00 && code_byte[6:0] > max_disp_reg)
                begin
                    max_disp_next = code_byte[6:0];
                end
            end

            b3_next  = b2_reg;
            b2_next  = b1_reg;
            b1_next  = code_byte;
            pos_next = pos_reg + PW'(1);
        end
    end

    // result taken from the state after this byte
    always_comb
    begin
        res.valid       = step && last_byte;
        res.convention  = ccs_pkg::CONV_CDECL;
        res.param_count = ccs_pkg::COUNT_UNKNOWN;
        disp_count      = max_disp_next[6:2] - 5'd1;
        if (32'(pos_next) >= 32'd4)
        begin
            if (this_found_next)
            begin
                res.convention = ccs_pkg::CONV_THISCALL;
            end
            else if (std_found_next)
            begin
                res.convention = ccs_pkg::CONV_STDCALL;
            end
            if (best_ret_next > 10'sd0)
            begin
                res.param_count = $signed(best_ret_next[9:2]);
            end
            else if (max_disp_next >= 7'd8 && 32'(disp_count) <= 32'(ccs_pkg::MAX_PARAMS))
            begin
                res.param_count = $signed({3'b000, disp_count});
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            b1_reg         <= '0;
            b2_reg         <= '0;
            b3_reg         <= '0;
            this_found_reg <= 1'b0;
            this_stop_reg  <= 1'b0;
            std_found_reg  <= 1'b0;
            best_ret_reg   <= -10'sd1;
            max_disp_reg   <= '0;
        end
        else if (step)
        begin
            if (last_byte)
            begin
                pos_reg        <= '0;
                b1_reg         <= '0;
                b2_reg         <= '0;
                b3_reg         <= '0;
                this_found_reg <= 1'b0;
                this_stop_reg  <= 1'b0;
                std_found_reg  <= 1'b0;
                best_ret_reg   <= -10'sd1;
                max_disp_reg   <= '0;
            end
            else
            begin
                pos_reg        <= pos_next;
                b1_reg         <= b1_next;
                b2_reg         <= b2_next;
                b3_reg         <= b3_next;
                this_found_reg <= this_found_next;
                this_stop_reg  <= this_stop_next;
                std_found_reg  <= std_found_next;
                best_ret_reg   <= best_ret_next;
                max_disp_reg   <= max_disp_next;
            end
        end
    end

    a_pos_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        32'(pos_reg) <= 32'(MAX_WINDOW))
        else $error("byte position past window");

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        step && last_byte |=> pos_reg == '0 && best_ret_reg == -10'sd1)
        else $error("state not cleared after last byte");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> res.param_count >= -8'sd1 && res.param_count <= 8'sd64)
        else $error("parameter count out of range");

    a_std_has_ret: assert property (@(posedge clk) disable iff (!rst_n)
        std_found_reg |-> best_ret_reg >= 10'sd0)
        else $error("stdcall flagged without a ret");

endmodule

>>> hdl/ccs_outreg.sv
module ccs_outreg (
    input  logic             clk,
    input  logic             rst_n,
    input  ccs_pkg::result_t res,
    output logic             space,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [15:0]      m_tdata
);

    logic              valid_reg;
    logic [1:0]        conv_reg;
    logic signed [7:0] count_reg;
    logic              load;

    assign space = !valid_reg || m_tready;
    assign load  = res.valid && space;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            conv_reg  <= res.convention;
            count_reg <= res.param_count;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {6'b000000, count_reg, conv_reg};

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int WINDOW       = ccs_pkg::MAX_WINDOW_DEF;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_BYTES = 1520;
    localparam int REPORT_MAX   = 10;

    // prologue bytes: push ebp / mov ebp,esp
    localparam logic [7:0] OP_PUSH_EBP  = 8'h55;
    localparam logic [7:0] OP_MOV_R_RM  = 8'h8B;
    localparam logic [7:0] MODRM_EBP_SP = 8'hEC;

    typedef struct packed {
        logic [1:0]        conv;
        logic signed [7:0] count;
    } verdict_t;

    typedef struct packed {
        logic [7:0]        code;
        logic              tail;
        logic              typed;
        logic [1:0]        conv;
        logic signed [7:0] count;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;

    int       cycle_count = 0;
    int       mismatch_count = 0;
    logic     quiet_span;
    verdict_t expected_verdicts[$];

    // predictor state
    int         scan_pos;
    logic [7:0] back1, back2, back3;
    bit         this_hit, this_halt, std_hit;
    int         best_ret;
    int         max_disp;

    stim_row_t directed_rows [0:27] = '{
        // one-byte body right after reset
        '{8'hFF,                 1'b1, 1'b1, ccs_pkg::CONV_CDECL, ccs_pkg::COUNT_UNKNOWN},
        // short body with a plain ret still gives cdecl unknown
        '{ccs_pkg::OP_POP_EBP,   1'b0, 1'b0, ccs_pkg::CONV_CDECL, ccs_pkg::COUNT_UNKNOWN},
        '{ccs_pkg::OP_RET,       1'b0, 1'b0, ccs_pkg::CONV_CDECL, ccs_pkg::COUNT_UNKNOWN},
        '{8'h00,                 1'b1, 1'b1, ccs_pkg::CONV_CDECL, ccs_pkg::COUNT_UNKNOWN},
        // mov [ebp-128],ecx at the earliest start offset
        '{8'h00,                 1'b0, 1'b0, ccs_pkg::CONV_CDECL, ccs_pkg::COUNT_UNKNOWN},
        '{8'h00,                 1'b0, 1'b0, ccs_pkg::CONV_CDECL, ccs_pkg::COUNT_UNKNOWN},
        '{8'h00,                 1'b0, 1'b0, ccs_pkg::CONV_CDECL, ccs_pkg::COUNT_UNKNOWN},
        '{ccs_pkg::OP_MOV_RM,    1'b0, 1'b0, ccs_pkg::CONV_CDECL, ccs_pkg::COUNT_UNKNOWN},
        '{ccs_pkg::MODRM_ECX_BP, 1'b0, 1'b0, ccs_pkg::CONV_CDECL, ccs_pkg::COUNT_UNKNOWN},
        '{ccs_pkg::DISP_NEG_MIN, 1'b1, 1'b1, ccs_pkg::CONV_THISCALL,
          ccs_pkg::COUNT_UNKNOWN},
        // pop ebp / ret 16
        '{ccs_pkg::OP_POP_EBP,   1'b0, 1'b0, ccs_pkg::CONV_CDECL, ccs_pkg::COUNT_UNKNOWN},
        '{ccs_pkg::OP_RET_IMM,   1'b0, 1'b0, ccs_pkg::CONV_CDECL, ccs_pkg::COUNT_UNKNOWN},
        '{8'h10,                 1'b0, 1'b0, ccs_pkg::CONV_CDECL, ccs_pkg::COUNT_UNKNOWN},
        '{8'h00,                 1'b1, 1'b1, ccs_pkg::CONV_STDCALL, 8'sd4},
        // ret 0 after a plain ret does not mark stdcall
        '{ccs_pkg::OP_POP_EBP,   1'b0, 1'b0, ccs_pkg::CONV_CDECL, ccs_pkg::COUNT_UNKNOWN},
        '{ccs_pkg::OP_RET,       1'b0, 1'b0, ccs_pkg::CONV_CDECL, ccs_pkg::COUNT_UNKNOWN},
        '{ccs_pkg::OP_LEAVE,     1'b0, 1'b0, ccs_pkg::CONV_CDECL, ccs_pkg::COUNT_UNKNOWN},
        '{ccs_pkg::OP_RET_IMM,   1'b0, 1'b0, ccs_pkg::CONV_CDECL, ccs_pkg::COUNT_UNKNOWN},
        '{8'h00,                 1'b0, 1'b0, ccs_pkg::CONV_CDECL, ccs_pkg::COUNT_UNKNOWN},
        '{8'h00,                 1'b1, 1'b1, ccs_pkg::CONV_CDECL, ccs_pkg::COUNT_UNKNOWN},
        // smallest parameter offset
        '{OP_MOV_R_RM,           1'b0, 1'b0, ccs_pkg::CONV_CDECL, ccs_pkg::COUNT_UNKNOWN},
        '{ccs_pkg::MODRM_BP_D8,  1'b0, 1'b0, ccs_pkg::CONV_CDECL, ccs_pkg::COUNT_UNKNOWN},
        '{ccs_pkg::DISP_MIN,     1'b0, 1'b0, ccs_pkg::CONV_CDECL, ccs_pkg::COUNT_UNKNOWN},
        '{8'hFF,                 1'b1, 1'b1, ccs_pkg::CONV_CDECL, 8'sd1},
        // leave / ret 256, largest immediate
        '{ccs_pkg::OP_LEAVE,     1'b0, 1'b0, ccs_pkg::CONV_CDECL, ccs_pkg::COUNT_UNKNOWN},
        '{ccs_pkg::OP_RET_IMM,   1'b0, 1'b0, ccs_pkg::CONV_CDECL, ccs_pkg::COUNT_UNKNOWN},
        '{8'h00,                 1'b0, 1'b0, ccs_pkg::CONV_CDECL, ccs_pkg::COUNT_UNKNOWN},
        '{8'h01,                 1'b1, 1'b0, ccs_pkg::CONV_CDECL, ccs_pkg::COUNT_UNKNOWN}
    };

    x86_calling_convention_scanner_top u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 clk = ~clk;

    assign quiet_span = cycle_count >= 600 && cycle_count < 1400;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        m_tready <= quiet_span || $urandom_range(99) >= 7;
    end

    function automatic void clear_scan();
        scan_pos  = 0;
        back1     = 8'h00;
        back2     = 8'h00;
        back3     = 8'h00;
        this_hit  = 1'b0;
        this_halt = 1'b0;
        std_hit   = 1'b0;
        best_ret  = -1;
        max_disp  = 0;
    endfunction

    function automatic void add_code_byte(ref logic [7:0] code[$], input logic [7:0] b);
        code.insert(code.size(), b);
    endfunction

    // returns 1 when the byte closes a body, with the verdict in v
    function automatic bit scan_predict(input logic [7:0] cur, input logic tail,
                                        output verdict_t v);
        int imm;
        int c;
        v = '{ccs_pkg::CONV_CDECL, ccs_pkg::COUNT_UNKNOWN};
        if (scan_pos < WINDOW)
        begin
            if (scan_pos >= 5 && !this_hit && !this_halt &&
                scan_pos - 2 < ccs_pkg::THIS_SCAN_LIMIT)
            begin
                if (back2 == ccs_pkg::OP_MOV_RM && back1 == ccs_pkg::MODRM_ECX_BP &&
                    cur >= ccs_pkg::DISP_NEG_MIN)
                    this_hit = 1'b1;
                else if (back2 == ccs_pkg::OP_INT3)
                    this_halt = 1'b1;
            end
            if (scan_pos >= 3 && (back3 == ccs_pkg::OP_POP_EBP || back3 == ccs_pkg::OP_LEAVE) &&
                back2 == ccs_pkg::OP_RET_IMM)
            begin
                imm = int'({cur, back1});
                if (imm <= ccs_pkg::RET_MAX && imm % 4 == 0 && imm > best_ret)
                begin
                    best_ret = imm;
                    std_hit  = 1'b1;
                end
            end
            if (scan_pos >= 2 && (back2 == ccs_pkg::OP_POP_EBP || back2 == ccs_pkg::OP_LEAVE) &&
                back1 == ccs_pkg::OP_RET && best_ret < 0)
                best_ret = 0;
            if (scan_pos >= 2 && (back1 & ccs_pkg::MODRM_MASK) == ccs_pkg::MODRM_BP_D8 &&
                cur >= ccs_pkg::DISP_MIN && cur <= ccs_pkg::DISP_MAX && cur[1:0] == 2'b00 &&
                int'(cur) > max_disp)
                max_disp = int'(cur);
            back3 = back2;
            back2 = back1;
            back1 = cur;
            scan_pos++;
        end
        if (!tail)
            return 1'b0;
        if (scan_pos >= 4)
        begin
            v.conv = this_hit ? ccs_pkg::CONV_THISCALL
                              : (std_hit ? ccs_pkg::CONV_STDCALL : ccs_pkg::CONV_CDECL);
            if (best_ret > 0)
                v.count = 8'(best_ret / 4);
            else if (max_disp >= 8)
            begin
                c = (max_disp - 4) / 4;
                if (c >= 1 && c <= ccs_pkg::MAX_PARAMS)
                    v.count = 8'(c);
            end
        end
        clear_scan();
        return 1'b1;
    endfunction

    task automatic feed_code_byte(input logic [7:0] code, input logic tail, input logic typed,
                                  input logic [1:0] conv, input logic signed [7:0] count);
        verdict_t v;
        while (!quiet_span && $urandom_range(99) < 7)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= code;
        s_tlast  <= tail;
        do
            @(posedge clk);
        while (!s_tready);
        if (scan_predict(code, tail, v))
        begin
            if (typed)
                v = '{conv, count};
            expected_verdicts.insert(expected_verdicts.size(), v);
        end
    endtask

    task automatic send_body(ref logic [7:0] code[$]);
        foreach (code[i])
            feed_code_byte(code[i], i == code.size() - 1, 1'b0, ccs_pkg::CONV_CDECL,
                           ccs_pkg::COUNT_UNKNOWN);
    endtask

    // mostly well-formed instruction fragments, some raw noise
    task automatic add_fragment(ref logic [7:0] code[$]);
        logic [15:0] imm;
        case ($urandom_range(9))
            0, 1, 2:
                add_code_byte(code, 8'($urandom));
            3:
            begin
                add_code_byte(code, ccs_pkg::OP_MOV_RM);
                add_code_byte(code, ccs_pkg::MODRM_ECX_BP);
                add_code_byte(code, 8'($urandom));
            end
            4:
                add_code_byte(code, ccs_pkg::OP_INT3);
            5, 6:
            begin
                add_code_byte(code, $urandom_range(1) ? ccs_pkg::OP_POP_EBP
                                                      : ccs_pkg::OP_LEAVE);
                if ($urandom_range(2) == 0)
                    add_code_byte(code, ccs_pkg::OP_RET);
                else
                begin
                    imm = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(70) * 4);
                    add_code_byte(code, ccs_pkg::OP_RET_IMM);
                    add_code_byte(code, imm[7:0]);
                    add_code_byte(code, imm[15:8]);
                end
            end
            7, 8:
            begin
                add_code_byte(code, ccs_pkg::MODRM_BP_D8 | 8'($urandom_range(7) << 3));
                add_code_byte(code, ($urandom_range(3) == 0) ? 8'($urandom)
                                                             : 8'($urandom_range(20) * 4));
            end
            default:
            begin
                add_code_byte(code, OP_PUSH_EBP);
                add_code_byte(code, OP_MOV_R_RM);
                add_code_byte(code, MODRM_EBP_SP);
            end
        endcase
    endtask

    always @(posedge clk)
    begin
        verdict_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_verdicts.size() == 0)
            begin
                if (mismatch_count < REPORT_MAX)
                    $display("unexpected result: convention %0d param_count %0d",
                             m_tdata[1:0], $signed(m_tdata[9:2]));
                mismatch_count++;
            end
            else
            begin
                want = expected_verdicts.pop_front();
                if (m_tdata[1:0] !== want.conv || m_tdata[9:2] !== want.count)
                begin
                    if (mismatch_count < REPORT_MAX)
                        $display({"result mismatch: convention exp %0d got %0d, ",
                                  "param_count exp %0d got %0d"},
                                 want.conv, m_tdata[1:0], want.count, $signed(m_tdata[9:2]));
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        logic [7:0] code[$];
        int sent;
        int target;
        clear_scan();
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= 8'h00;
        s_tlast  <= 1'b0;
        m_tready <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            feed_code_byte(directed_rows[i].code, directed_rows[i].tail, directed_rows[i].typed,
                           directed_rows[i].conv, directed_rows[i].count);
        s_tvalid <= 1'b0;
        // hold off until every result of the directed bodies is out
        while (expected_verdicts.size() != 0)
            @(posedge clk);

        sent = 0;
        while (sent < RANDOM_BYTES)
        begin
            code.delete();
            target = ($urandom_range(7) == 0) ? $urandom_range(1, 150)
                                              : $urandom_range(1, 40);
            while (code.size() < target)
                add_fragment(code);
            while (code.size() > target)
                void'(code.pop_back());
            send_body(code);
            sent += target;
        end
        s_tvalid <= 1'b0;

        while (expected_verdicts.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && expected_verdicts.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> filelist.f
hdl/ccs_pkg.sv
hdl/ccs_scan.sv
hdl/ccs_outreg.sv
hdl/x86_calling_convention_scanner_top.sv
bench/testbench.sv
